// File: hw/rtl/de_bruijn_prr_successor_generator_unit_assert.svh
// assertion macros used by the checker file dbps_chk.sv
`ifndef DE_BRUIJN_PRR_SUCCESSOR_GENERATOR_UNIT_ASSERT_SVH
`define DE_BRUIJN_PRR_SUCCESSOR_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DBPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dbps assertion failed");

// next-cycle implication
`define DBPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dbps assertion failed");

`endif

// File: hw/rtl/dbps_pkg.sv
// shared constants and types of the de bruijn successor generator
package dbps_pkg;

	localparam int MAX_ORDER = 32;
	localparam int ORDER_W   = 6;
	localparam int WIN_AW    = $clog2(MAX_ORDER);
	localparam int CNT_W     = MAX_ORDER + 1;
	localparam int RUN_DEPTH = MAX_ORDER + 2;
	localparam int RUN_AW    = $clog2(RUN_DEPTH);
	localparam int RUN_W     = ORDER_W;

	localparam logic [MAX_ORDER-1:0] START_WIN = {(MAX_ORDER/2){2'b10}};

	localparam logic       REG_ORDER = 1'b0;
	localparam logic       REG_RULE  = 1'b1;

	localparam logic [1:0] MODE_OPP = 2'd0;
	localparam logic [1:0] MODE_LC  = 2'd1;
	localparam logic [1:0] MODE_RL  = 2'd2;

	typedef struct packed {
		logic                 start;
		logic [MAX_ORDER-1:0] x;
		logic [ORDER_W-1:0]   n;
		logic [1:0]           mode;
	} eval_req_t;

	typedef struct packed {
		logic done;
		logic member;
	} eval_rsp_t;

endpackage

// File: hw/rtl/dbps_ram.sv
// generic ram, one write port and two registered read ports
module dbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: hw/rtl/dbps_eval.sv
// membership test sequencer: bit scan, prr shift, least rotation over stored runs
module dbps_eval import dbps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  eval_req_t req,
	output eval_rsp_t rsp
);

	typedef enum logic [7:0] {
		E_IDLE = 8'b0000_0001,
		E_SPS  = 8'b0000_0010,
		E_PRT  = 8'b0000_0100,
		E_PRS  = 8'b0000_1000,
		E_RLS  = 8'b0001_0000,
		E_LRR  = 8'b0010_0000,
		E_LRC  = 8'b0100_0000,
		E_MOD  = 8'b1000_0000
	} est_t;

	est_t                 st_q;
	logic [1:0]           mode_q;
	logic [ORDER_W-1:0]   n_q;
	logic [MAX_ORDER-1:0] x_q, cur_q;
	logic                 sb_phase_q, sw_q, sb_q;
	logic [RUN_AW-1:0]    i_q, r_q, p_q, rem_q;
	logic [RUN_W-1:0]     j_q, run2_q, t_q;
	logic                 ok_q, okp_q;
	logic                 done_q, mem_q;

	logic                 bi, bnx, cont;
	logic [RUN_W-1:0]     len;
	logic [RUN_AW-1:0]    k;
	logic                 ok_new, okp_new, special_end;
	logic                 fb;
	logic [MAX_ORDER-1:0] shifted;
	logic                 t_go;
	logic [RUN_W-1:0]     da, db;
	logic                 rl_fin;
	logic                 ram_we;

	always_comb begin
		bi      = cur_q[WIN_AW'(i_q - 6'd1)];
		bnx     = cur_q[WIN_AW'(i_q)];
		cont    = (i_q < n_q) && (bi == bnx);
		len     = j_q + 6'd1;
		k       = r_q + 6'd1;
		ok_new  = (k >= 6'd3) ? (ok_q && (len == run2_q)) : ok_q;
		okp_new = (k >= 6'd3) ? ok_q : okp_q;
		// odd run count, middle runs equal, leading 1 0, last run longer
		special_end = k[0] && (k >= 6'd3) && okp_new && cur_q[0] && !cur_q[1]
			&& (len > run2_q);
		fb      = cur_q[0] ^ cur_q[1] ^ cur_q[WIN_AW'(n_q - 6'd1)];
		shifted = (cur_q >> 1) | (MAX_ORDER'(fb) << (n_q - 6'd1));
		t_go    = (t_q < (n_q - 6'd1))
			&& (cur_q[WIN_AW'(t_q)] == cur_q[WIN_AW'(t_q + 6'd1)]);
		ram_we  = (st_q == E_RLS) && !cont;
		// rotation accepted and length divisible by period
		if (cur_q[0] == cur_q[WIN_AW'(n_q - 6'd1)]) begin
			rl_fin = (rem_q == '0) && ((p_q == r_q) || !cur_q[0] || !p_q[0]);
		end else begin
			rl_fin = (rem_q == '0) && !cur_q[0];
		end
	end

	dbps_ram #(.WIDTH(RUN_W), .DEPTH(RUN_DEPTH)) u_runs (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (k),
		.wdata   (len),
		.raddr_a (i_q - p_q),
		.raddr_b (i_q),
		.rdata_a (da),
		.rdata_b (db)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			done_q <= 1'b0;
			mem_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (req.start) begin
						mode_q     <= req.mode;
						n_q        <= req.n;
						x_q        <= req.x;
						cur_q      <= req.x;
						sb_phase_q <= 1'b0;
						i_q        <= (req.mode == MODE_RL) ? 6'd2 : 6'd1;
						j_q        <= '0;
						r_q        <= '0;
						ok_q       <= 1'b1;
						okp_q      <= 1'b1;
						t_q        <= 6'd1;
						priority if (req.mode == MODE_OPP) begin
							st_q <= E_SPS;
						end else if (req.mode == MODE_LC && req.x[0] != req.x[1]) begin
							st_q <= E_PRT;
						end else if (req.mode == MODE_RL) begin
							st_q <= E_RLS;
						end else begin
							done_q <= 1'b1;
							mem_q  <= 1'b0;
						end
					end
				end
				E_SPS: begin
					i_q <= i_q + 6'd1;
					if (cont) begin
						j_q <= j_q + 6'd1;
					end else begin
						j_q   <= '0;
						r_q   <= k;
						ok_q  <= ok_new;
						okp_q <= okp_new;
						if (k == 6'd2) begin
							run2_q <= len;
						end
						if (i_q == n_q) begin
							if (!sb_phase_q) begin
								sw_q <= special_end;
								t_q  <= 6'd1;
								st_q <= E_PRT;
							end else begin
								sb_q <= special_end;
								if (x_q[0] != x_q[1]) begin
									i_q  <= 6'd2;
									j_q  <= '0;
									r_q  <= '0;
									st_q <= E_RLS;
								end else begin
									done_q <= 1'b1;
									mem_q  <= sw_q;
									st_q   <= E_IDLE;
								end
							end
						end
					end
				end
				E_PRT: begin
					if (t_go) begin
						t_q <= t_q + 6'd1;
					end else begin
						st_q <= E_PRS;
					end
				end
				E_PRS: begin
					cur_q <= shifted;
					t_q   <= t_q - 6'd1;
					if (t_q == 6'd1) begin
						i_q   <= (mode_q == MODE_OPP) ? 6'd1 : 6'd2;
						j_q   <= '0;
						r_q   <= '0;
						ok_q  <= 1'b1;
						okp_q <= 1'b1;
						sb_phase_q <= 1'b1;
						st_q  <= (mode_q == MODE_OPP) ? E_SPS : E_RLS;
					end
				end
				E_RLS: begin
					i_q <= i_q + 6'd1;
					if (cont) begin
						j_q <= j_q + 6'd1;
					end else begin
						j_q <= '0;
						r_q <= k;
						if (i_q == n_q) begin
							priority if (k == 6'd1) begin
								done_q <= 1'b1;
								mem_q  <= (mode_q == MODE_OPP) ? (sw_q | !sb_q) : 1'b1;
								st_q   <= E_IDLE;
							end else if (cur_q[0] == cur_q[1]) begin
								done_q <= 1'b1;
								mem_q  <= (mode_q == MODE_OPP) ? sw_q : 1'b0;
								st_q   <= E_IDLE;
							end else begin
								i_q  <= 6'd2;
								p_q  <= 6'd1;
								st_q <= E_LRR;
							end
						end
					end
				end
				E_LRR: begin
					st_q <= E_LRC;
				end
				E_LRC: begin
					if (da > db) begin
						done_q <= 1'b1;
						mem_q  <= (mode_q == MODE_OPP) ? sw_q : 1'b0;
						st_q   <= E_IDLE;
					end else begin
						if (da < db) begin
							p_q <= i_q;
						end
						if (i_q == r_q) begin
							rem_q <= r_q;
							st_q  <= E_MOD;
						end else begin
							i_q  <= i_q + 6'd1;
							st_q <= E_LRR;
						end
					end
				end
				E_MOD: begin
					if (rem_q >= p_q) begin
						rem_q <= rem_q - p_q;
					end else begin
						done_q <= 1'b1;
						mem_q  <= (mode_q == MODE_OPP) ? (sw_q | (rl_fin & !sb_q)) : rl_fin;
						st_q   <= E_IDLE;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.member = mem_q;

endmodule

// File: hw/rtl/de_bruijn_prr_successor_generator_unit.sv
// top level of the de bruijn prr successor generator
//
// channel   dir  signals                          content
// s_axis    in   tvalid tready tdata[7:0]         tdata[0] restart
// m_axis    out  tvalid tready tdata[7:0] tlast   tdata[0] seq_bit, tlast period_end
// cfg       in   valid ready index data[5:0]      index 0 order, 1 rule_mode
//
// one bit takes two membership tests in the shared evaluator, each made of up to
// two run scans, the prr shift, a run scan into the run ram, least-rotation steps
// and a remainder loop, or ended at once when the first two bits decide; the top
// level steps through its own control states around them.
// s_axis_tready is low while a bit is worked on; the output register holds one
// result, and a stalled m_axis only delays the next bit. reset loads order 3,
// rule 0, the alternating window and a zero bit count.
module de_bruijn_prr_successor_generator_unit import dbps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [0] restart, [7:1] zero
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,  // [0] seq_bit, [7:1] zero
	output logic               m_axis_tlast,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [ORDER_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_EV1  = 4'b0010,
		T_EV2  = 4'b0100,
		T_FIN  = 4'b1000
	} tst_t;

	tst_t                 st_q;
	logic [ORDER_W-1:0]   order_q;
	logic [1:0]           rule_q;
	logic [MAX_ORDER-1:0] win_q, w_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rep_q;
	logic                 ov_q, obit_q, olast_q;

	logic [ORDER_W-1:0]   n;
	logic [MAX_ORDER-1:0] mask, base, nw;
	logic [CNT_W-1:0]     period, cnt1;
	logic                 s_acc, out_free, v;
	eval_req_t            req;
	eval_rsp_t            rsp;

	always_comb begin
		priority if (order_q < 6'd3) begin
			n = 6'd3;
		end else if (order_q > ORDER_W'(MAX_ORDER)) begin
			n = ORDER_W'(MAX_ORDER);
		end else begin
			n = order_q;
		end
		mask     = {MAX_ORDER{1'b1}} >> (ORDER_W'(MAX_ORDER) - n);
		period   = CNT_W'(1) << n;
		s_acc    = s_axis_tvalid && s_axis_tready;
		out_free = !ov_q || m_axis_tready;
		base     = (s_axis_tdata[0] ? START_WIN : win_q) & mask;
		v        = w_q[0] ^ w_q[1] ^ w_q[WIN_AW'(n - 6'd1)];
		nw       = (w_q >> 1) | (MAX_ORDER'(v ^ rep_q) << (n - 6'd1));
		cnt1     = cnt_q + CNT_W'(1);
		req.start = (st_q == T_IDLE && s_acc) || (st_q == T_EV1 && rsp.done);
		req.x     = (st_q == T_IDLE) ? base : (w_q ^ MAX_ORDER'(1));
		req.n     = n;
		req.mode  = rule_q;
	end

	dbps_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= T_IDLE;
			order_q <= 6'd3;
			rule_q  <= MODE_OPP;
			win_q   <= START_WIN;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			olast_q <= 1'b0;
			obit_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ORDER: order_q <= cfg_data;
					REG_RULE:  rule_q  <= cfg_data[1:0];
					default:   ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready && !(st_q == T_FIN && out_free)) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (s_acc) begin
						w_q <= base;
						if (s_axis_tdata[0]) begin
							win_q <= START_WIN;
							cnt_q <= '0;
						end
						st_q <= T_EV1;
					end
				end
				T_EV1: begin
					if (rsp.done) begin
						rep_q <= rsp.member;
						st_q  <= T_EV2;
					end
				end
				T_EV2: begin
					if (rsp.done) begin
						rep_q <= rep_q | rsp.member;
						st_q  <= T_FIN;
					end
				end
				T_FIN: begin
					if (out_free) begin
						ov_q   <= 1'b1;
						obit_q <= w_q[0];
						win_q  <= (win_q & ~mask) | (nw & mask);
						if (cnt1 >= period) begin
							olast_q <= 1'b1;
							cnt_q   <= '0;
						end else begin
							olast_q <= 1'b0;
							cnt_q   <= cnt1;
						end
						st_q <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (st_q == T_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {7'd0, obit_q};
	assign m_axis_tlast  = olast_q;

endmodule

// File: hw/rtl/dbps_chk.sv
// port-level checker for the generator, bound to the top level
`include "de_bruijn_prr_successor_generator_unit_assert.svh"

module dbps_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// a transfer in starts work, so the block is busy next cycle
	`DBPS_ASSERT_NXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a stalled result holds
	`DBPS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	// a new result only comes out of a busy cycle
	`DBPS_ASSERT_IMP(a_out_from_work, clk, arst_n, m_axis_tvalid && !$past(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind de_bruijn_prr_successor_generator_unit dbps_chk u_dbps_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// File: dv/testbench.sv
// self-checking testbench of the de bruijn prr successor generator
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dbps_pkg::*;

	typedef struct packed {
		logic seq_bit;
		logic period_end;
	} gen_bit_t;

	typedef struct {
		logic     restart;
		logic     known;
		gen_bit_t bits;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // [0] restart
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [7:0]         m_axis_tdata;   // [0] seq_bit
	logic               m_axis_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [ORDER_W-1:0] cfg_data;

	de_bruijn_prr_successor_generator_unit u_dut (.*);

	// predictor state
	logic [5:0]           gen_order;
	logic [1:0]           gen_mode;
	logic [MAX_ORDER-1:0] gen_win;
	logic [CNT_W-1:0]     gen_count;

	gen_bit_t bits_due[$];
	int       errors;
	int       got;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("de_bruijn_prr_successor_generator_unit verification failed");
		$finish;
	end

	function automatic logic bit_of(logic [63:0] w, int i);
		return w[i-1];
	endfunction

	function automatic int run_lengths(logic [63:0] w, int s, int m, ref int run[36]);
		int r, j;
		r = 0;
		j = 0;
		for (int i = s; i <= m; i++) begin
			if (i < m && bit_of(w, i) == bit_of(w, i + 1)) begin
				j++;
			end else begin
				r++;
				run[r] = j + 1;
				j = 0;
			end
		end
		return r;
	endfunction

	function automatic logic special_form(logic [63:0] w, int n);
		int run[36];
		int r;
		r = run_lengths(w, 1, n, run);
		if (r % 2 == 0 || r < 3) return 1'b0;
		for (int i = 3; i < r; i++)
			if (run[i] != run[2]) return 1'b0;
		return bit_of(w, 1) && !bit_of(w, 2) && run[r] > run[2];
	endfunction

	function automatic logic [63:0] prr_advance(logic [63:0] w, int n);
		int t;
		logic fb;
		t = 1;
		w = w & ((64'd1 << n) - 1);
		while (t < n - 1 && bit_of(w, t + 1) == bit_of(w, t + 2)) t++;
		for (int k = 0; k < t; k++) begin
			fb = bit_of(w, 1) ^ bit_of(w, 2) ^ bit_of(w, n);
			w = (w >> 1) | (64'(fb) << (n - 1));
		end
		return w;
	endfunction

	function automatic int min_rotation_period(int run[36], int len);
		int p;
		p = 1;
		for (int i = 2; i <= len; i++) begin
			if (run[i-p] > run[i]) return 0;
			if (run[i-p] < run[i]) p = i;
		end
		if (len % p != 0) return 0;
		return p;
	endfunction

	function automatic logic in_rl(logic [63:0] w, int n);
		int run[36];
		int r, p;
		logic a1, an;
		r = run_lengths(w, 2, n, run);
		a1 = bit_of(w, 1);
		an = bit_of(w, n);
		if (r == 1) return 1'b1;
		if (a1 == bit_of(w, 2)) return 1'b0;
		p = min_rotation_period(run, r);
		if (a1 == an && p > 0 && (p == r || !a1 || p % 2 == 0)) return 1'b1;
		if (a1 != an && p > 0 && !a1) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic in_lc(logic [63:0] w, int n);
		if (bit_of(w, 1) == bit_of(w, 2)) return 1'b0;
		return in_rl(prr_advance(w, n), n);
	endfunction

	function automatic logic in_rule(logic [63:0] w, int n, logic [1:0] mode);
		case (mode)
			MODE_OPP: return special_form(w, n) ||
				(in_lc(w, n) && !special_form(prr_advance(w, n), n));
			MODE_LC:  return in_lc(w, n);
			MODE_RL:  return in_rl(w, n);
			default:  return 1'b0;
		endcase
	endfunction

	function automatic gen_bit_t next_bit(logic restart);
		int n;
		logic [63:0] mask, w;
		logic v, flip;
		gen_bit_t res;
		n = gen_order < 3 ? 3 : (gen_order > MAX_ORDER ? MAX_ORDER : int'(gen_order));
		mask = (64'd1 << n) - 1;
		if (restart) begin
			gen_win = START_WIN;
			gen_count = '0;
		end
		w = 64'(gen_win) & mask;
		res.seq_bit = bit_of(w, 1);
		v = bit_of(w, 1) ^ bit_of(w, 2) ^ bit_of(w, n);
		flip = in_rule(w, n, gen_mode) || in_rule(w ^ 64'd1, n, gen_mode);
		w = (w >> 1) | (64'(v ^ flip) << (n - 1));
		gen_win = MAX_ORDER'((64'(gen_win) & ~mask) | (w & mask));
		gen_count++;
		if (64'(gen_count) >= (64'd1 << n)) begin
			res.period_end = 1'b1;
			gen_count = '0;
		end else begin
			res.period_end = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic g, logic e);
		errors++;
		$display("mismatch on bit %0d: %s got %0b expected %0b", got, what, g, e);
	endtask

	// receiver with its own stall pattern
	int stall_phase;
	always @(posedge clk) begin
		gen_bit_t exp_bit;
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			m_axis_tready <= (stall_phase % 64 < 16) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (m_axis_tvalid && m_axis_tready) begin
				if (bits_due.size() == 0) begin
					report_mismatch("unexpected transfer", 1'b1, 1'b0);
				end else begin
					exp_bit = bits_due.pop_front();
					if (m_axis_tdata[0] !== exp_bit.seq_bit)
						report_mismatch("seq_bit", m_axis_tdata[0], exp_bit.seq_bit);
					if (m_axis_tlast !== exp_bit.period_end)
						report_mismatch("period_end", m_axis_tlast, exp_bit.period_end);
					if (m_axis_tdata[7:1] !== 7'd0)
						report_mismatch("pad", 1'b1, 1'b0);
				end
				got++;
			end
		end else begin
			stall_phase <= 0;
			m_axis_tready <= 1'b0;
		end
	end

	task automatic write_reg(logic idx, logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_ORDER) gen_order = val;
		else gen_mode = val[1:0];
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (bits_due.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("de_bruijn_prr_successor_generator_unit verification failed");
			$finish;
		end
		repeat (400) @(posedge clk);
	endtask

	int burst_left;
	task automatic send_item(logic restart, logic known, gen_bit_t typed);
		gen_bit_t pred;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, restart};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		pred = next_bit(restart);
		if (known && pred !== typed)
			report_mismatch("typed row seq_bit", pred.seq_bit, typed.seq_bit);
		bits_due.push_back(known ? typed : pred);
	endtask

	stim_row_t directed[] = '{
		// after reset: window 0101 with a1 = 0, order 3
		'{1'b0, 1'b1, 2'b00},
		'{1'b1, 1'b1, 2'b00},
		'{1'b0, 1'b0, 2'b00}, '{1'b0, 1'b0, 2'b00}, '{1'b0, 1'b0, 2'b00},
		'{1'b0, 1'b0, 2'b00}, '{1'b0, 1'b0, 2'b00}, '{1'b0, 1'b0, 2'b00},
		'{1'b0, 1'b0, 2'b00}, '{1'b1, 1'b1, 2'b00}, '{1'b0, 1'b0, 2'b00}
	};

	initial begin
		int modes[4];
		int orders[8];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ORDER;
		cfg_data = '0;
		errors = 0;
		got = 0;
		burst_left = 0;
		gen_order = 3;
		gen_mode = MODE_OPP;
		gen_win = START_WIN;
		gen_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].restart, directed[i].known, directed[i].bits);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		wait_drained();
		// extremes of order and mode, including out-of-range and unused mode
		orders = '{0, 2, 3, 32, 63, 4, 5, 6};
		foreach (orders[i]) begin
			write_reg(REG_ORDER, 6'(orders[i]));
			write_reg(REG_RULE, 6'(i % 4));
			for (int k = 0; k < 6; k++) send_item(k == 0, 1'b0, '0);
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			wait_drained();
		end

		// random phases: mostly small orders so periods wrap
		modes = '{0, 1, 2, 3};
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_ORDER,
				6'((ph % 5 == 4) ? $urandom_range(0, 63) : $urandom_range(3, 6)));
			write_reg(REG_RULE, 6'(modes[$urandom_range(0, 3)]));
			for (int k = 0; k < 60; k++) begin
				send_item(k == 0 || $urandom_range(0, 40) == 0, 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			wait_drained();
		end

		if (errors == 0)
			$display("de_bruijn_prr_successor_generator_unit verification clean");
		else
			$display("de_bruijn_prr_successor_generator_unit verification failed");
		$finish;
	end
endmodule
